### sv/vec3_normalize_assert.svh
// Assertion macros for the vec3_normalize block.
// Used by the port checker; no other dependencies.
`ifndef VEC3_NORMALIZE_ASSERT_SVH
`define VEC3_NORMALIZE_ASSERT_SVH

// same-cycle implication
`define V3N_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("vec3_normalize check failed");

// next-cycle implication
`define V3N_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("vec3_normalize check failed");

`endif

### sv/v3n_pkg.sv
// Shared types and constants for vec3_normalize.
// No dependencies.
package v3n_pkg;

  localparam int unsigned CompW   = 16;
  localparam int unsigned SumW    = 32;
  localparam int unsigned RootW   = 16;
  localparam int unsigned QuotW   = 15;
  localparam int unsigned SqrtRemW = RootW + 2;
  localparam int unsigned DivRemW = RootW + 1;
  localparam int unsigned NumLanes = 3;
  localparam logic [QuotW-1:0] OneQ14 = 15'd16384;

  // item in flight through the square-root cells
  typedef struct packed {
    logic [SumW-1:0]                     rad;   // remaining radicand bits, MSB first
    logic [SqrtRemW-1:0]                 rem;
    logic [RootW-1:0]                    root;
    logic [NumLanes-1:0][CompW-1:0]      comp;
  } sqrt_t;

  // item in flight through the divider cells
  typedef struct packed {
    logic [RootW-1:0]                    len;
    logic                                zero;
    logic [NumLanes-1:0]                 neg;
    logic [NumLanes-1:0]                 nbit;  // dividend bit still to shift in
    logic [NumLanes-1:0][DivRemW-1:0]    rem;
    logic [NumLanes-1:0][QuotW-1:0]      quot;
  } div_t;

endpackage

### sv/vec3_normalize.sv
// vec3_normalize: normalizes a signed 16-bit 3-vector to Q1.14 and returns its length.
// Input item on s_axis: tdata = {z, y, x}, x in the low bits.
// Output item on m_axis: tdata = {vec_length, unit_z, unit_y, unit_x}, tuser = zero_vector.
// Components are |c|*16384/len truncated toward zero, sign restored, clamped to
// +-16384; len = floor(sqrt(x^2+y^2+z^2)). A zero vector gives all zeros and
// tuser set.
// Throughput: one item per clock while m_axis_tready is high. Pipeline: 33 register
// stages: 1 square stage, 1 sum stage, 16 square-root cells, one per root
// bit, 15 divider cells, one per quotient bit, shared by the three components.
// Every stage is a register with its own valid; a stage takes a new item when it
// is empty or its successor takes its item, so bubbles collapse and a stalled
// receiver fills the chain before s_axis_tready drops.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// Depends on v3n_pkg, v3n_sqrt_cell, v3n_div_cell.
module vec3_normalize (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // vec_x[15:0], vec_y[31:16], vec_z[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // unit_x, unit_y, unit_z, vec_length (low to high)
  output logic        m_axis_tuser    // zero_vector
);

  localparam int unsigned SqW = 2 * v3n_pkg::CompW - 1;

  // square stage
  logic sq_vld_q, sq_rdy;
  logic [v3n_pkg::NumLanes-1:0][SqW-1:0]           sq_q;
  logic [v3n_pkg::NumLanes-1:0][SqW-1:0]           sq_d;
  logic [v3n_pkg::NumLanes-1:0][v3n_pkg::CompW-1:0] sq_comp_q;

  // sum stage
  logic sum_vld_q, sum_rdy;
  v3n_pkg::sqrt_t sum_q;

  logic [v3n_pkg::RootW:0]        sq_vld, sq_rdy_c;
  v3n_pkg::sqrt_t [v3n_pkg::RootW:0] sq_dat;
  logic [v3n_pkg::QuotW:0]        dv_vld, dv_rdy;
  v3n_pkg::div_t  [v3n_pkg::QuotW:0] dv_dat;
  v3n_pkg::div_t                  dv_in;

  assign sq_rdy = !sq_vld_q || sum_rdy;
  assign sum_rdy = !sum_vld_q || sq_rdy_c[0];
  assign s_axis_tready = sq_rdy;

  // squares at full width: operands sign-extended before the multiply
  always_comb begin
    logic signed [2*v3n_pkg::CompW-1:0] cx;
    cx = '0;
    for (int l = 0; l < v3n_pkg::NumLanes; l++) begin
      cx = {{v3n_pkg::CompW{s_axis_tdata[l*v3n_pkg::CompW + v3n_pkg::CompW - 1]}},
            s_axis_tdata[l*v3n_pkg::CompW +: v3n_pkg::CompW]};
      sq_d[l] = SqW'(cx * cx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q  <= 1'b0;
      sum_vld_q <= 1'b0;
    end else begin
      if (sq_rdy) sq_vld_q <= s_axis_tvalid;
      if (sum_rdy) sum_vld_q <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_rdy && s_axis_tvalid) begin
      for (int l = 0; l < v3n_pkg::NumLanes; l++) begin
        sq_comp_q[l] <= s_axis_tdata[l*v3n_pkg::CompW +: v3n_pkg::CompW];
        sq_q[l] <= sq_d[l];
      end
    end
    if (sum_rdy && sq_vld_q) begin
      sum_q.rad  <= v3n_pkg::SumW'({1'b0, sq_q[0]}) + v3n_pkg::SumW'({1'b0, sq_q[1]})
                  + v3n_pkg::SumW'({1'b0, sq_q[2]});
      sum_q.rem  <= '0;
      sum_q.root <= '0;
      sum_q.comp <= sq_comp_q;
    end
  end

  assign sq_vld[0] = sum_vld_q;
  assign sq_dat[0] = sum_q;

  for (genvar i = 0; i < v3n_pkg::RootW; i++) begin : g_sqrt
    v3n_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_vld[i]),
      .ready_o (sq_rdy_c[i]),
      .data_i  (sq_dat[i]),
      .valid_o (sq_vld[i+1]),
      .ready_i (sq_rdy_c[i+1]),
      .data_o  (sq_dat[i+1])
    );
  end

  assign sq_rdy_c[v3n_pkg::RootW] = dv_rdy[0];

  // hand-off into the dividers: remainder starts at |c|>>1, |c| lsb shifted in first
  always_comb begin
    logic [v3n_pkg::CompW-1:0] mag;
    dv_in      = '0;
    dv_in.len  = sq_dat[v3n_pkg::RootW].root;
    dv_in.zero = (sq_dat[v3n_pkg::RootW].root == '0);
    for (int l = 0; l < v3n_pkg::NumLanes; l++) begin
      mag = sq_dat[v3n_pkg::RootW].comp[l][v3n_pkg::CompW-1]
          ? v3n_pkg::CompW'(-sq_dat[v3n_pkg::RootW].comp[l])
          : sq_dat[v3n_pkg::RootW].comp[l];
      dv_in.neg[l]  = sq_dat[v3n_pkg::RootW].comp[l][v3n_pkg::CompW-1];
      dv_in.nbit[l] = mag[0];
      dv_in.rem[l]  = v3n_pkg::DivRemW'(mag >> 1);
    end
  end
  assign dv_dat[0] = dv_in;
  assign dv_vld[0] = sq_vld[v3n_pkg::RootW];

  for (genvar i = 0; i < v3n_pkg::QuotW; i++) begin : g_div
    v3n_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_vld[i]),
      .ready_o (dv_rdy[i]),
      .data_i  (dv_dat[i]),
      .valid_o (dv_vld[i+1]),
      .ready_i (dv_rdy[i+1]),
      .data_o  (dv_dat[i+1])
    );
  end

  assign dv_rdy[v3n_pkg::QuotW] = m_axis_tready;
  assign m_axis_tvalid = dv_vld[v3n_pkg::QuotW];

  always_comb begin
    logic [v3n_pkg::QuotW-1:0] q;
    m_axis_tdata = '0;
    for (int l = 0; l < v3n_pkg::NumLanes; l++) begin
      q = dv_dat[v3n_pkg::QuotW].quot[l];
      if (q > v3n_pkg::OneQ14) q = v3n_pkg::OneQ14;
      if (!dv_dat[v3n_pkg::QuotW].zero) begin
        m_axis_tdata[l*v3n_pkg::CompW +: v3n_pkg::CompW] = dv_dat[v3n_pkg::QuotW].neg[l]
          ? v3n_pkg::CompW'(-{1'b0, q}) : v3n_pkg::CompW'({1'b0, q});
      end
    end
    m_axis_tdata[3*v3n_pkg::CompW +: v3n_pkg::RootW] = dv_dat[v3n_pkg::QuotW].len;
  end
  assign m_axis_tuser = dv_dat[v3n_pkg::QuotW].zero;

endmodule

### sv/v3n_sqrt_cell.sv
// One digit step of the integer square root, registered, with handshake.
// Depends on v3n_pkg.
module v3n_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  v3n_pkg::sqrt_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output v3n_pkg::sqrt_t data_o
);

  logic           vld_q;
  v3n_pkg::sqrt_t dat_q, dat_d;
  logic [v3n_pkg::SqrtRemW:0]   r2;
  logic [v3n_pkg::SqrtRemW-1:0] trial;

  assign ready_o = !vld_q || ready_i;

  always_comb begin
    dat_d = data_i;
    r2    = {data_i.rem[v3n_pkg::SqrtRemW-2:0], data_i.rad[v3n_pkg::SumW-1 -: 2]};
    trial = {data_i.root, 2'b01};
    dat_d.rad = {data_i.rad[v3n_pkg::SumW-3:0], 2'b00};
    if (r2 >= {1'b0, trial}) begin
      dat_d.rem  = v3n_pkg::SqrtRemW'(r2 - {1'b0, trial});
      dat_d.root = {data_i.root[v3n_pkg::RootW-2:0], 1'b1};
    end else begin
      dat_d.rem  = r2[v3n_pkg::SqrtRemW-1:0];
      dat_d.root = {data_i.root[v3n_pkg::RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dat_q <= dat_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = dat_q;

endmodule

### sv/v3n_div_cell.sv
// One quotient bit of the three component divisions, registered, with handshake.
// Depends on v3n_pkg.
module v3n_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  v3n_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output v3n_pkg::div_t data_o
);

  logic          vld_q;
  v3n_pkg::div_t dat_q, dat_d;
  logic [v3n_pkg::DivRemW-1:0] r2;

  assign ready_o = !vld_q || ready_i;

  always_comb begin
    dat_d      = data_i;
    dat_d.nbit = '0;
    r2         = '0;
    for (int l = 0; l < v3n_pkg::NumLanes; l++) begin
      r2 = {data_i.rem[l][v3n_pkg::DivRemW-2:0], data_i.nbit[l]};
      if (r2 >= {1'b0, data_i.len}) begin
        dat_d.rem[l]  = r2 - {1'b0, data_i.len};
        dat_d.quot[l] = {data_i.quot[l][v3n_pkg::QuotW-2:0], 1'b1};
      end else begin
        dat_d.rem[l]  = r2;
        dat_d.quot[l] = {data_i.quot[l][v3n_pkg::QuotW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dat_q <= dat_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = dat_q;

endmodule

### sv/v3n_checker.sv
// Port-level checker for vec3_normalize, bound to the top level.
// Depends on vec3_normalize_assert.svh.
`include "vec3_normalize_assert.svh"

module v3n_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `V3N_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `V3N_ASSERT_NOW(a_zero_out, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 64'd0)
  `V3N_ASSERT_NOW(a_len_nz, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[63:48] != 16'd0)
  `V3N_ASSERT_NEXT(a_rdy_empty, clk_i, rst_ni, !m_axis_tvalid && !s_axis_tvalid, s_axis_tready)

endmodule

bind vec3_normalize v3n_checker u_v3n_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### bench/vec3_normalize_test.sv
// Testbench for vec3_normalize: drives vectors on s_axis, checks m_axis items
// against a built-in integer predictor. Depends on vec3_normalize.
`timescale 1ns / 1ps

module vec3_normalize_test;

  typedef struct packed {
    logic        zero;
    logic [15:0] len;
    logic [15:0] uz;
    logic [15:0] uy;
    logic [15:0] ux;
  } norm_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic [47:0] vec_queue[$];
  norm_res_t   expected_units[$];
  int          n_errors = 0;
  int          n_cycles = 0;
  bit          stim_done = 1'b0;
  bit          calm = 1'b0;   // no idling on either side
  bit          in_taken = 1'b0;   // input item accepted at the last rising edge

  vec3_normalize dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] sqrt_floor(logic [31:0] n);
    logic [31:0] root;
    logic [31:0] bitv;
    root = 0;
    bitv = 32'h4000_0000;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] unit_of(logic signed [15:0] c, logic [31:0] len);
    logic [31:0] mag;
    logic [31:0] q;
    mag = (c < 0) ? -32'(c) : 32'(c);
    q = (mag * 32'd16384) / len;
    if (q > 32'd16384) q = 32'd16384;
    if (c < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic norm_res_t normalize(logic [47:0] v);
    norm_res_t r;
    logic signed [15:0] x, y, z;
    int xi, yi, zi;
    logic [31:0] sum, len;
    x = v[15:0];
    y = v[31:16];
    z = v[47:32];
    xi = x;
    yi = y;
    zi = z;
    sum = 32'(xi * xi) + 32'(yi * yi) + 32'(zi * zi);
    len = sqrt_floor(sum);
    r = '0;
    if (len == 0) begin
      r.zero = 1'b1;
    end else begin
      r.ux = unit_of(x, len);
      r.uy = unit_of(y, len);
      r.uz = unit_of(z, len);
      r.len = len[15:0];
    end
    return r;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, n_cycles);
    n_errors++;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000 + 16'($urandom_range(0, 3));
      1: return 16'h7fff - 16'($urandom_range(0, 3));
      2: return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (vec_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= vec_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 22);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    norm_res_t got, want;
    n_cycles <= n_cycles + 1;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) expected_units.push_back(normalize(s_axis_tdata));
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (expected_units.size() == 0) begin
        report("unexpected item", got.ux, 16'h0);
      end else begin
        want = expected_units.pop_front();
        if (got.ux != want.ux) report("unit_x", got.ux, want.ux);
        if (got.uy != want.uy) report("unit_y", got.uy, want.uy);
        if (got.uz != want.uz) report("unit_z", got.uz, want.uz);
        if (got.len != want.len) report("vec_length", got.len, want.len);
        if (got.zero != want.zero) report("zero_vector", 16'(got.zero), 16'(want.zero));
      end
    end
    if (n_cycles > 400000) begin
      $display("vec3_normalize verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (vec_queue.size() != 0 || s_axis_tvalid || expected_units.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] edges[6];
    edges = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h8001};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: zero, diagonals, axes, extremes of both signs
    vec_queue.push_back(48'h0);
    for (int i = 0; i < 6; i++) vec_queue.push_back({edges[i], edges[i], edges[i]});
    for (int i = 0; i < 6; i++) vec_queue.push_back({16'h0, 16'h0, edges[i]});
    for (int i = 0; i < 6; i++) vec_queue.push_back({16'h0, edges[i], 16'h0});
    for (int i = 0; i < 6; i++) vec_queue.push_back({edges[i], 16'h0, 16'h0});
    wait_drained();   // sender holds off until all results are back
    for (int i = 0; i < 1750; i++) begin
      if (i == 600) begin
        wait_drained();
        calm = 1'b1;
      end
      if (i == 900) calm = 1'b0;
      vec_queue.push_back({rand_comp(), rand_comp(), rand_comp()});
      if (vec_queue.size() > 8) @(posedge clk_i);
    end
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (n_errors == 0 && expected_units.size() == 0) begin
      $display("vec3_normalize verification clean");
    end else begin
      $display("vec3_normalize verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/v3n_pkg.sv
sv/v3n_sqrt_cell.sv
sv/v3n_div_cell.sv
sv/vec3_normalize.sv
sv/v3n_checker.sv
bench/vec3_normalize_test.sv
